### hw/rtl/mcsc_pkg.sv
// Shared types, constants and state codes of the mip chain size calculator.
`default_nettype none

package mcsc_pkg;

   localparam int MAX_LEVELS_DEF = 16;
   localparam int DIM_BITS_DEF   = 16;

   localparam int FIELD_W = 16;
   localparam int TYPE_W  = 3;
   localparam int COUNT_W = 5;
   localparam int BPP_W   = 8;
   localparam int QUERY_W = 4;
   localparam int LA_W    = 13;
   localparam int BYTES_W = 53;
   localparam int CHAIN_W = 57;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LA_W-1:0]   LA_RESET = 13'd1;
   localparam logic [TYPE_W-1:0] TYPE_3D  = 3'd4;

   // Register index, taken from paddr[2]
   localparam logic REG_LINE_ALIGN = 1'b0;

   typedef struct packed {
      logic [FIELD_W-1:0] base_width;
      logic [FIELD_W-1:0] base_height;
      logic [FIELD_W-1:0] base_depth;
      logic [TYPE_W-1:0]  image_type;
      logic [COUNT_W-1:0] level_count;
      logic [BPP_W-1:0]   bits_per_pixel;
      logic               is_compressed;
      logic [QUERY_W-1:0] query_level;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] level_width;
      logic [FIELD_W-1:0] level_height;
      logic [FIELD_W-1:0] level_depth;
      logic [BYTES_W-1:0] level_bytes;
      logic [CHAIN_W-1:0] chain_bytes;
      logic [COUNT_W-1:0] max_level_count;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic slot_free;
   } seq_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_ACC,
      ST_SUM,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

### hw/rtl/mip_chain_size_calculator_core.sv
// Mip chain size calculator: one texture description in, one size result out.
//
// A request transfer carries a texture description and a queried level; the
// block answers with one response transfer holding the queried level's
// dimensions and byte size, the byte size of the stored chain and the
// greatest possible level count. Line alignment is set through the CSR port
// at byte address 0. The user must write it only while the block is idle;
// the block itself does not enforce this. Each chain level is worked through
// the shared multiplier in turn, an uncompressed one also through the
// bit-serial row remainder unit; the response also waits for the level count
// search. The chain walk covers the stored level count clamped to
// 1..MAX_LEVELS, plus the queried level when it lies past MAX_LEVELS but
// within the stored count. One request is worked on at a time; req_stall
// stays high until the result has moved to the output register, so a new
// request may enter while a response waits. A stalled response holds its
// payload. Reset returns the sequencer to idle, drops any pending response
// and sets line alignment to 1.
`default_nettype none

module mip_chain_size_calculator_core #(
   parameter int MAX_LEVELS = mcsc_pkg::MAX_LEVELS_DEF,
   parameter int DIM_BITS   = mcsc_pkg::DIM_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire mcsc_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output mcsc_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mcsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mcsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [mcsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   logic [mcsc_pkg::LA_W-1:0] la_ff;
   logic [mcsc_pkg::LA_W-1:0] la_eff;
   logic                      csr_write;
   logic                      rsp_valid_ff;
   mcsc_pkg::rsp_type         rsp_ff;
   mcsc_pkg::rsp_type         seq_rsp;
   mcsc_pkg::seq_ctl_type     seq_ctl;
   mcsc_pkg::seq_sts_type     seq_sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         la_ff <= mcsc_pkg::LA_RESET;
      end else if (csr_write && csr_paddr[2] == mcsc_pkg::REG_LINE_ALIGN) begin
         la_ff <= csr_pwdata[mcsc_pkg::LA_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == mcsc_pkg::REG_LINE_ALIGN) begin
         csr_prdata = mcsc_pkg::CSR_DATA_W'(la_ff);
      end
   end

   // Zero alignment means no padding
   assign la_eff = (la_ff == '0) ? mcsc_pkg::LA_W'(1) : la_ff;

   assign req_stall         = !seq_sts.idle;
   assign seq_ctl.start     = req_valid && !req_stall;
   assign seq_ctl.slot_free = !rsp_valid_ff || !rsp_stall;

   mcsc_seq #(
      .MAX_LEVELS (MAX_LEVELS),
      .DIM_BITS   (DIM_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .ctl        (seq_ctl),
      .req        (req_data),
      .line_align (la_eff),
      .sts        (seq_sts),
      .rsp        (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_sts.done && seq_ctl.slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_sts.done && seq_ctl.slot_free) begin
         rsp_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted without the sequencer going busy");

   a_result_lands : assert property (@(posedge clock) disable iff (reset)
      seq_sts.done && seq_ctl.slot_free |=> rsp_valid)
      else $error("finished result did not reach the output register");

   a_level_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.max_level_count != '0)
      else $error("response carries a zero maximum level count");

endmodule

`default_nettype wire

### hw/rtl/mcsc_mul.sv
// Shared multiplier with a registered product.
`default_nettype none

module mcsc_mul #(
   parameter int A_W = 22,
   parameter int B_W = 16
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic      [A_W+B_W-1:0] p
);

   logic [A_W+B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
      end
   end

   assign p = prod_ff;

endmodule

`default_nettype wire

### hw/rtl/mcsc_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module mcsc_rem #(
   parameter int DVD_W = 21,
   parameter int DIV_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  busy,
   output logic      [DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DIV_W-1:0] div_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W:0]   trial;
   logic             fits;
   logic [DIV_W-1:0] rem_in;

   // Shift the next dividend bit in; subtract when the divisor fits
   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= CNT_W'(DVD_W);
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/mcsc_seq.sv
// Level sequencer: walks the mip levels through the shared multiplier and remainder unit.
`default_nettype none

module mcsc_seq #(
   parameter int MAX_LEVELS = mcsc_pkg::MAX_LEVELS_DEF,
   parameter int DIM_BITS   = mcsc_pkg::DIM_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mcsc_pkg::seq_ctl_type      ctl,
   input  wire mcsc_pkg::req_type          req,
   input  wire logic [mcsc_pkg::LA_W-1:0]  line_align,
   output mcsc_pkg::seq_sts_type           sts,
   output mcsc_pkg::rsp_type               rsp
);

   localparam int D      = DIM_BITS;
   localparam int CW     = mcsc_pkg::COUNT_W;
   localparam int LAW    = mcsc_pkg::LA_W;
   localparam int PROW_W = D + mcsc_pkg::BPP_W;
   localparam int ROW_W  = PROW_W - 3;
   localparam int RP_W   = ((ROW_W > LAW) ? ROW_W : LAW) + 1;
   localparam int M1_W   = RP_W + D;
   localparam int H_W    = (M1_W + 1) / 2;
   localparam int HI_W   = M1_W - H_W;
   localparam int LS_W   = M1_W + D;

   mcsc_pkg::seq_state_type state_ff, state_in;

   logic [D-1:0]    b0_ff, b1_ff, b2_ff;
   logic            is3d_ff;
   logic            comp_ff;
   logic [CW-1:0]   count_ff;
   logic [D-1:0]    bpp_ff;
   logic [CW-1:0]   q_ff;
   logic [LAW-1:0]  la_ff;
   logic [CW-1:0]   level_ff;
   logic            extra_ff;
   logic [RP_W-1:0] rowpad_ff;
   logic [HI_W-1:0] mhi_ff;
   logic [LS_W-1:0] size_ff;
   logic [mcsc_pkg::CHAIN_W-1:0] chain_ff;
   logic [LS_W-1:0] qbytes_ff;
   logic [D-1:0]    mx_ff;
   logic [CW-1:0]   lg_ff;

   logic [D-1:0]    in_b0, in_b1, in_b2, in_max;
   logic            in_3d;
   logic [D-1:0]    l0, l1, l2, dc0, dc1, dc2;
   logic [D-1:0]    qd0, qd1, qd2;
   logic            q_absent;
   logic [CW-1:0]   n_lv;
   logic            last_level;
   logic            need_extra;
   logic [ROW_W-1:0] row;
   logic            lg_done;

   logic            mul_en;
   logic [RP_W-1:0] mul_a;
   logic [D-1:0]    mul_b;
   logic [M1_W-1:0] prod;
   logic            rem_start;
   logic            rem_busy;
   logic [LAW-1:0]  rem;

   function automatic logic [D-1:0] halve(input logic [D-1:0] v, input logic [CW-1:0] s);
      logic [D-1:0] r;
      r = v >> s;
      return (r == '0) ? D'(1) : r;
   endfunction

   // Round up to a multiple of four, wrapping at the dimension width
   function automatic logic [D-1:0] round4(input logic [D-1:0] v);
      logic [D-3:0] hi;
      hi = (D-2)'(v[D-1:2] + 1'b1);
      return (v[1:0] != 2'b00) ? {hi, 2'b00} : v;
   endfunction

   mcsc_mul #(
      .A_W (RP_W),
      .B_W (D)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   mcsc_rem #(
      .DVD_W (ROW_W),
      .DIV_W (LAW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (row),
      .divisor   (la_ff),
      .busy      (rem_busy),
      .remainder (rem)
   );

   always_comb begin
      in_b0  = D'(req.base_width);
      in_b1  = D'(req.base_height);
      in_b2  = D'(req.base_depth);
      in_3d  = req.image_type == mcsc_pkg::TYPE_3D;
      in_max = (in_b0 > in_b1) ? in_b0 : in_b1;
      if (in_3d && in_b2 > in_max) begin
         in_max = in_b2;
      end
   end

   // Dimensions of the level in flight, block-rounded if compressed (depth only for 3D)
   always_comb begin
      l0  = halve(b0_ff, level_ff);
      l1  = halve(b1_ff, level_ff);
      l2  = is3d_ff ? halve(b2_ff, level_ff) : b2_ff;
      dc0 = comp_ff ? round4(l0) : l0;
      dc1 = comp_ff ? round4(l1) : l1;
      dc2 = (comp_ff && is3d_ff) ? round4(l2) : l2;
   end

   always_comb begin
      if (count_ff == '0) begin
         n_lv = CW'(1);
      end else if (count_ff > CW'(MAX_LEVELS)) begin
         n_lv = CW'(MAX_LEVELS);
      end else begin
         n_lv = count_ff;
      end
      last_level = ({1'b0, level_ff} + 1'b1) >= {1'b0, n_lv};
      need_extra = (q_ff < count_ff) && (q_ff >= n_lv);
      row        = prod[PROW_W-1:3];
      lg_done    = mx_ff <= D'(1);
   end

   always_comb begin
      state_in  = state_ff;
      mul_en    = 1'b0;
      mul_a     = RP_W'(dc0);
      mul_b     = bpp_ff;
      rem_start = 1'b0;
      sts.idle  = 1'b0;
      sts.done  = 1'b0;
      unique case (state_ff)
         mcsc_pkg::ST_IDLE: begin
            sts.idle = 1'b1;
            if (ctl.start) begin
               state_in = mcsc_pkg::ST_ROW;
            end
         end
         mcsc_pkg::ST_ROW: begin
            mul_en   = 1'b1;
            state_in = mcsc_pkg::ST_DIVGO;
         end
         mcsc_pkg::ST_DIVGO: begin
            rem_start = !comp_ff;
            state_in  = comp_ff ? mcsc_pkg::ST_M1 : mcsc_pkg::ST_DIVWAIT;
         end
         mcsc_pkg::ST_DIVWAIT: begin
            if (!rem_busy) begin
               state_in = mcsc_pkg::ST_M1;
            end
         end
         mcsc_pkg::ST_M1: begin
            mul_en   = 1'b1;
            mul_a    = rowpad_ff;
            mul_b    = dc1;
            state_in = mcsc_pkg::ST_M2;
         end
         mcsc_pkg::ST_M2: begin
            mul_en   = 1'b1;
            mul_a    = RP_W'(prod[H_W-1:0]);
            mul_b    = dc2;
            state_in = mcsc_pkg::ST_M3;
         end
         mcsc_pkg::ST_M3: begin
            mul_en   = 1'b1;
            mul_a    = RP_W'(mhi_ff);
            mul_b    = dc2;
            state_in = mcsc_pkg::ST_ACC;
         end
         mcsc_pkg::ST_ACC: begin
            state_in = mcsc_pkg::ST_SUM;
         end
         mcsc_pkg::ST_SUM: begin
            if (!extra_ff && (!last_level || need_extra)) begin
               state_in = mcsc_pkg::ST_ROW;
            end else begin
               state_in = mcsc_pkg::ST_DONE;
            end
         end
         mcsc_pkg::ST_DONE: begin
            sts.done = lg_done;
            if (lg_done && ctl.slot_free) begin
               state_in = mcsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mcsc_pkg::ST_IDLE && ctl.start) begin
         b0_ff     <= in_b0;
         b1_ff     <= in_b1;
         b2_ff     <= in_b2;
         is3d_ff   <= in_3d;
         comp_ff   <= req.is_compressed;
         count_ff  <= req.level_count;
         bpp_ff    <= D'(req.bits_per_pixel);
         q_ff      <= CW'(req.query_level);
         la_ff     <= line_align;
         level_ff  <= '0;
         extra_ff  <= 1'b0;
         chain_ff  <= '0;
         qbytes_ff <= '0;
      end
      if (state_ff == mcsc_pkg::ST_DIVGO) begin
         rowpad_ff <= RP_W'(row);
      end
      if (state_ff == mcsc_pkg::ST_DIVWAIT && !rem_busy) begin
         rowpad_ff <= RP_W'(row) + RP_W'((rem == '0) ? '0 : la_ff - rem);
      end
      if (state_ff == mcsc_pkg::ST_M2) begin
         mhi_ff <= prod[M1_W-1:H_W];
      end
      if (state_ff == mcsc_pkg::ST_M3) begin
         size_ff <= LS_W'(prod);
      end
      if (state_ff == mcsc_pkg::ST_ACC) begin
         size_ff <= size_ff + (LS_W'(prod) << H_W);
      end
      if (state_ff == mcsc_pkg::ST_SUM) begin
         if (!extra_ff) begin
            chain_ff <= chain_ff + mcsc_pkg::CHAIN_W'(size_ff);
         end
         if (level_ff == q_ff) begin
            qbytes_ff <= size_ff;
         end
         // Advance along the chain, or jump to a queried level beyond it
         if (!extra_ff && !last_level) begin
            level_ff <= level_ff + 1'b1;
         end else if (!extra_ff && need_extra) begin
            level_ff <= q_ff;
            extra_ff <= 1'b1;
         end
      end
   end

   // Level count search runs alongside the chain walk
   always_ff @(posedge clock) begin
      if (state_ff == mcsc_pkg::ST_IDLE && ctl.start) begin
         mx_ff <= in_max;
         lg_ff <= '0;
      end else if (!lg_done) begin
         mx_ff <= mx_ff >> 1;
         lg_ff <= lg_ff + 1'b1;
      end
   end

   always_comb begin
      q_absent = (q_ff >= count_ff) && (q_ff != '0);
      qd0      = q_absent ? '0 : halve(b0_ff, q_ff);
      qd1      = q_absent ? '0 : halve(b1_ff, q_ff);
      if (q_absent) begin
         qd2 = '0;
      end else begin
         qd2 = is3d_ff ? halve(b2_ff, q_ff) : b2_ff;
      end
      rsp.level_width     = mcsc_pkg::FIELD_W'(qd0);
      rsp.level_height    = mcsc_pkg::FIELD_W'(qd1);
      rsp.level_depth     = mcsc_pkg::FIELD_W'(qd2);
      rsp.level_bytes     = mcsc_pkg::BYTES_W'(qbytes_ff);
      rsp.chain_bytes     = chain_ff;
      rsp.max_level_count = lg_ff + 1'b1;
   end

endmodule

`default_nettype wire
